// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, skipped while reset is high.
`define CHK_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Check a property at each rising clock edge, reset included.
`define CHK_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/dmc_pkg.sv =====
// Package: geometry, types and operation codes of the direct-mapped cache.
`timescale 1ns / 1ps

package dmc_pkg;

  localparam int LINES          = 16;
  localparam int WORDS_PER_LINE = 4;
  localparam int TAG_BITS       = 4;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 10;
  localparam int COUNT_W        = 32;

  localparam int WORD_BITS = $clog2(WORDS_PER_LINE);
  localparam int LINE_BITS = $clog2(LINES);
  localparam int SLOT_BITS = WORD_BITS + LINE_BITS;
  localparam int SLOTS     = LINES * WORDS_PER_LINE;

  typedef logic [WORD_BITS-1:0] word_sel_t;
  typedef logic [LINE_BITS-1:0] line_sel_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [COUNT_W-1:0]   count_t;

  // Operation codes carried on func
  typedef enum logic {
    FUNC_STORE = 1'b0,
    FUNC_LOAD  = 1'b1
  } func_t;

endpackage

// ===== hw/rtl/direct_mapped_cache_lines_top.sv =====
// Top level: direct-mapped word cache with line metadata and hit counter.
`timescale 1ns / 1ps

// Direct-mapped word cache, 16 lines of 4 words of 32 bits. Address bits
// 1:0 pick the word, 5:2 the line and 9:6 the tag. Each request transaction
// is a store (func 0) or a load (func 1, data_in is the backing word used
// for a fill) and yields exactly one response transaction with the cached
// word after the access, the hit flag and the running hit total. The word
// memory is read at the edge that accepts a request, and the request then
// does the read-modify-write in the access stage, held while a stalled
// response fills the response register, before it lands there. The word
// memory's single read port and single write port set the rate: a new
// request is taken in the same cycle the previous one writes back, so the
// block sustains one request per cycle while responses are taken, with
// write data forwarded when the incoming request reads the word being
// written. Line tags, valid, dirty and last-word flags sit in flip-flops;
// the word memory carries one written bit per word, so no clearing pass is
// needed after reset.
module direct_mapped_cache_lines_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [0:0]                 func,
  input  logic [dmc_pkg::ADDR_W-1:0] address,
  input  logic [dmc_pkg::DATA_W-1:0] data_in,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [dmc_pkg::DATA_W-1:0] read_data,
  output logic                       hit,
  output logic [dmc_pkg::COUNT_W-1:0] hit_count
);

  // Word memory and its written bits
  dmc_pkg::data_t mem [dmc_pkg::SLOTS];
  logic [dmc_pkg::SLOTS-1:0] written;

  // Line metadata
  logic [dmc_pkg::LINES-1:0] line_valid;
  logic [dmc_pkg::LINES-1:0] line_dirty;
  dmc_pkg::tag_t      line_tag  [dmc_pkg::LINES];
  dmc_pkg::word_sel_t last_word [dmc_pkg::LINES];
  dmc_pkg::count_t    hits;

  // Access stage registers
  logic               s1_valid;
  logic               s1_load;
  dmc_pkg::tag_t      s1_tag;
  dmc_pkg::line_sel_t s1_line;
  dmc_pkg::word_sel_t s1_word;
  dmc_pkg::data_t     s1_data;
  dmc_pkg::data_t     s1_rdata;

  // Request fields
  dmc_pkg::word_sel_t req_word;
  dmc_pkg::line_sel_t req_line;
  dmc_pkg::tag_t      req_tag;
  dmc_pkg::slot_t     req_slot;

  logic               req_acc;
  logic               s1_done;
  logic               s1_hit;
  logic               s1_keep;
  logic               wr_en;
  dmc_pkg::slot_t     wr_slot;
  dmc_pkg::data_t     cur_word;
  dmc_pkg::data_t     rsp_data_next;
  dmc_pkg::count_t    hits_next;
  logic               dirty_next;

  // Split the address
  assign req_word = address[dmc_pkg::WORD_BITS-1:0];
  assign req_line = address[dmc_pkg::SLOT_BITS-1:dmc_pkg::WORD_BITS];
  assign req_tag  = address[dmc_pkg::SLOT_BITS+dmc_pkg::TAG_BITS-1:dmc_pkg::SLOT_BITS];
  assign req_slot = {req_line, req_word};

  // Advance the access stage when the response register is free
  assign s1_done   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_done;
  assign req_acc   = req_valid && !req_stall;

  // Look up the line and decide the update
  always_comb begin
    s1_hit   = line_valid[s1_line] && (line_tag[s1_line] == s1_tag);
    cur_word = written[{s1_line, s1_word}] ? s1_rdata : '0;
    s1_keep  = s1_load && s1_hit && (last_word[s1_line] == s1_word);
    wr_en    = s1_done && !s1_keep;
    wr_slot  = {s1_line, s1_word};
    rsp_data_next = s1_keep ? cur_word : s1_data;
    hits_next = hits + dmc_pkg::COUNT_W'(s1_hit);
    dirty_next = line_dirty[s1_line];
    if (s1_keep) begin
      dirty_next = 1'b0;
    end else if (!s1_load && line_valid[s1_line]) begin
      dirty_next = 1'b1;
    end
  end

  // Word memory: write back, registered read with forwarding
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= s1_data;
    end
    if (req_acc) begin
      if (wr_en && (wr_slot == req_slot)) begin
        s1_rdata <= s1_data;
      end else begin
        s1_rdata <= mem[req_slot];
      end
    end
  end

  // Access stage payload
  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_load <= (func == dmc_pkg::FUNC_LOAD);
      s1_tag  <= req_tag;
      s1_line <= req_line;
      s1_word <= req_word;
      s1_data <= data_in;
    end
  end

  // Control state and line metadata
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      rsp_valid  <= 1'b0;
      written    <= '0;
      line_valid <= '0;
      line_dirty <= '0;
      hits       <= '0;
      for (int i = 0; i < dmc_pkg::LINES; i++) begin
        line_tag[i]  <= '0;
        last_word[i] <= '0;
      end
    end else begin
      if (req_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end

      if (s1_done) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (wr_en) begin
        written[wr_slot]     <= 1'b1;
        line_valid[s1_line]  <= 1'b1;
        line_tag[s1_line]    <= s1_tag;
      end
      if (s1_done) begin
        line_dirty[s1_line] <= dirty_next;
        last_word[s1_line]  <= s1_word;
        hits                <= hits_next;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (s1_done) begin
      read_data <= rsp_data_next;
      hit       <= s1_hit;
      hit_count <= hits_next;
    end
  end

endmodule

// ===== hw/rtl/dmc_checker.sv =====
// Checker: port-level assertions on the direct-mapped cache, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic [dmc_pkg::DATA_W-1:0]  read_data,
  input logic                        hit,
  input logic [dmc_pkg::COUNT_W-1:0] hit_count
);

  logic            rsp_acc;
  dmc_pkg::count_t last_count;

  assign rsp_acc = rsp_valid && !rsp_stall;

  // Track the hit total of the latest response transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (rsp_acc) begin
      last_count <= hit_count;
    end
  end

  // Hit total moves by exactly the hit flag from one response to the next
  `CHK_ASSERT(a_count_step, rsp_acc |-> (hit_count == last_count + dmc_pkg::COUNT_W'(hit)))

  // No response right after reset
  `CHK_ASSERT_ALWAYS(a_reset_idle, ($past(rst) && !rst) |-> !rsp_valid)

  // Hold a stalled response payload
  `CHK_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> ($stable(read_data) && $stable(hit) && $stable(hit_count)))

endmodule

bind direct_mapped_cache_lines_top dmc_checker u_dmc_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .read_data (read_data),
  .hit       (hit),
  .hit_count (hit_count)
);

// ===== tb/tb_direct_mapped_cache_lines_top.sv =====
// Testbench for the direct-mapped word cache: directed and random accesses checked against a predictor.
`timescale 1ns / 1ps

module tb_direct_mapped_cache_lines_top;

  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ACCESSES = 900;
  localparam int CALM_TAIL = 150;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [dmc_pkg::ADDR_W-1:0] addr_t;

  typedef struct {
    dmc_pkg::func_t op;
    addr_t          addr;
    dmc_pkg::data_t data;
  } access_t;

  typedef struct {
    dmc_pkg::data_t  word;
    logic            hit;
    dmc_pkg::count_t hits;
  } lookup_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_stall;
  logic [0:0]      func = dmc_pkg::FUNC_STORE;
  addr_t           address = '0;
  dmc_pkg::data_t  data_in = '0;
  logic            rsp_valid;
  logic            rsp_stall = 1'b0;
  dmc_pkg::data_t  read_data;
  logic            hit;
  dmc_pkg::count_t hit_count;

  access_t access_q[$];
  lookup_t lookup_q[$];
  int      total_accesses = 0;
  int      taken_cnt = 0;
  int      errors = 0;
  int      cycles = 0;
  int      idle_odds = 0;
  int      send_gap = 0;
  int      stall_left = 0;
  int      hold_left = 0;
  logic    hold_fired = 1'b0;
  logic    req_taken = 1'b0;
  logic    calm;

  // Shadow copy of the cache contents and line metadata
  dmc_pkg::data_t     shadow_word [dmc_pkg::SLOTS] = '{default: '0};
  dmc_pkg::tag_t      shadow_tag  [dmc_pkg::LINES] = '{default: '0};
  logic               shadow_valid[dmc_pkg::LINES] = '{default: 1'b0};
  logic               shadow_dirty[dmc_pkg::LINES] = '{default: 1'b0};
  dmc_pkg::word_sel_t shadow_last [dmc_pkg::LINES] = '{default: '0};
  dmc_pkg::count_t    shadow_hits = '0;

  direct_mapped_cache_lines_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .address   (address),
    .data_in   (data_in),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .read_data (read_data),
    .hit       (hit),
    .hit_count (hit_count)
  );

  always #5 clk = ~clk;

  // Drop all idling once the last stretch of the run is reached
  assign calm = (taken_cnt + CALM_TAIL >= total_accesses);

  // Apply one access to the shadow cache and return the word, hit and hit total
  function automatic lookup_t cache_lookup(dmc_pkg::func_t op, addr_t a, dmc_pkg::data_t d);
    dmc_pkg::word_sel_t w;
    dmc_pkg::line_sel_t l;
    dmc_pkg::tag_t      t;
    dmc_pkg::slot_t     s;
    logic               is_hit;
    lookup_t            r;
    w = a[dmc_pkg::WORD_BITS-1:0];
    l = a[dmc_pkg::WORD_BITS +: dmc_pkg::LINE_BITS];
    t = a[dmc_pkg::SLOT_BITS +: dmc_pkg::TAG_BITS];
    s = {l, w};
    is_hit = shadow_valid[l] && (shadow_tag[l] == t);
    if (is_hit) shadow_hits = shadow_hits + 1'b1;
    if (op == dmc_pkg::FUNC_STORE) begin
      if (shadow_valid[l]) shadow_dirty[l] = 1'b1;
      shadow_valid[l] = 1'b1;
      shadow_tag[l] = t;
      shadow_word[s] = d;
    end else if (is_hit && shadow_last[l] == w) begin
      // same word hit again: no fill, line is clean
      shadow_dirty[l] = 1'b0;
    end else begin
      shadow_valid[l] = 1'b1;
      shadow_tag[l] = t;
      shadow_word[s] = d;
    end
    shadow_last[l] = w;
    r.word = shadow_word[s];
    r.hit = is_hit;
    r.hits = shadow_hits;
    return r;
  endfunction

  task automatic queue_access(dmc_pkg::func_t op, addr_t a, dmc_pkg::data_t d);
    access_t x;
    x.op = op;
    x.addr = a;
    x.data = d;
    access_q.push_back(x);
  endtask

  // Cycle counter, idling phases and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 128 == 0) begin
      case ($urandom_range(0, 2))
        0: idle_odds <= 0;
        1: idle_odds <= 4;
        default: idle_odds <= 12;
      endcase
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Request driver: advance to the next access once the current one is taken
  always @(negedge clk) begin : request_driver
    access_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else if (!req_valid || req_taken) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        req_valid <= 1'b0;
      end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        send_gap <= $urandom_range(0, 18);
        req_valid <= 1'b0;
      end else if (access_q.size() != 0) begin
        nxt = access_q.pop_front();
        req_valid <= 1'b1;
        func <= nxt.op;
        address <= nxt.addr;
        data_in <= nxt.data;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once, so the response side fills up and the cache stalls requests
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_fired && taken_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Response stall in random bursts
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_left != 0) begin
      rsp_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_stall <= 1'b1;
    end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left <= $urandom_range(0, 18);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Monitor: check each response transaction, predict each request transaction
  always @(posedge clk) begin : monitor
    lookup_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (lookup_q.size() == 0) begin
          errors++;
          $display("%t: unexpected response read_data=%h hit=%b hit_count=%0d",
                   $time, read_data, hit, hit_count);
        end else begin
          want = lookup_q.pop_front();
          if (read_data !== want.word) begin
            errors++;
            $display("%t: read_data expected %h actual %h", $time, want.word, read_data);
          end
          if (hit !== want.hit) begin
            errors++;
            $display("%t: hit expected %b actual %b", $time, want.hit, hit);
          end
          if (hit_count !== want.hits) begin
            errors++;
            $display("%t: hit_count expected %0d actual %0d", $time, want.hits, hit_count);
          end
        end
      end
      if (req_valid && !req_stall) begin
        lookup_q.push_back(cache_lookup(dmc_pkg::func_t'(func), address, data_in));
        taken_cnt <= taken_cnt + 1;
        req_taken <= 1'b1;
      end else begin
        req_taken <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    addr_t          a;
    dmc_pkg::data_t d;
    // load on an invalid line, then same-word hit and other-word hit
    queue_access(dmc_pkg::FUNC_LOAD,  10'h000, 32'hFFFF_FFFF);
    queue_access(dmc_pkg::FUNC_LOAD,  10'h000, 32'h0000_0000);
    queue_access(dmc_pkg::FUNC_LOAD,  10'h001, 32'h1234_5678);
    // store hit, store miss on a valid line, load miss on a valid line
    queue_access(dmc_pkg::FUNC_STORE, 10'h001, 32'h0000_0000);
    queue_access(dmc_pkg::FUNC_STORE, 10'h3C0, 32'hDEAD_BEEF);
    queue_access(dmc_pkg::FUNC_LOAD,  10'h000, 32'hCAFE_F00D);
    queue_access(dmc_pkg::FUNC_LOAD,  10'h3C0, 32'h5555_5555);
    // store on an invalid line at the top address, then hits on that line
    queue_access(dmc_pkg::FUNC_STORE, 10'h3FF, 32'hFFFF_FFFF);
    queue_access(dmc_pkg::FUNC_LOAD,  10'h3FF, 32'h0000_0000);
    queue_access(dmc_pkg::FUNC_LOAD,  10'h3FC, 32'hA5A5_A5A5);
    queue_access(dmc_pkg::FUNC_STORE, 10'h3FC, 32'h8000_0001);
    queue_access(dmc_pkg::FUNC_LOAD,  10'h3FC, 32'h7FFF_FFFE);
    // store then load of the same word returns the stored word
    queue_access(dmc_pkg::FUNC_STORE, 10'h004, 32'h0000_0000);
    queue_access(dmc_pkg::FUNC_LOAD,  10'h004, 32'h1234_5678);
    queue_access(dmc_pkg::FUNC_LOAD,  10'h005, 32'hFFFF_FFFF);
    queue_access(dmc_pkg::FUNC_STORE, 10'h2AA, 32'hAAAA_AAAA);
    queue_access(dmc_pkg::FUNC_LOAD,  10'h155, 32'h5555_5555);
    queue_access(dmc_pkg::FUNC_LOAD,  10'h2AA, 32'h0F0F_0F0F);
    // random part: mostly a small working set so hits and repeats are common
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        a[dmc_pkg::WORD_BITS-1:0] =
          dmc_pkg::word_sel_t'($urandom_range(0, dmc_pkg::WORDS_PER_LINE - 1));
        a[dmc_pkg::WORD_BITS +: dmc_pkg::LINE_BITS] =
          dmc_pkg::line_sel_t'($urandom_range(0, 3));
        a[dmc_pkg::SLOT_BITS +: dmc_pkg::TAG_BITS] = ($urandom_range(0, 5) == 0)
          ? dmc_pkg::tag_t'($urandom_range(0, 15))
          : dmc_pkg::tag_t'($urandom_range(0, 1));
      end else begin
        a = addr_t'($urandom_range(0, 1023));
      end
      case ($urandom_range(0, 7))
        0: d = '0;
        1: d = '1;
        default: d = $urandom;
      endcase
      queue_access(dmc_pkg::func_t'($urandom_range(0, 1)), a, d);
    end
    total_accesses = access_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_cnt != total_accesses || lookup_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && lookup_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== direct_mapped_cache_lines_top.f =====
+incdir+hw/rtl
hw/rtl/dmc_pkg.sv
hw/rtl/direct_mapped_cache_lines_top.sv
hw/rtl/dmc_checker.sv
tb/tb_direct_mapped_cache_lines_top.sv
